### rtl/ebalu_pkg.sv
// ebalu_pkg: request/response types and operation codes for the 8-bit ALU.
// No dependencies; used by eight_bit_alu_with_flags.
package ebalu_pkg;

	// Flag bit positions inside a 4-bit flag field
	localparam int unsigned FLAG_Z = 3;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_H = 1;
	localparam int unsigned FLAG_C = 0;

	// Operation codes
	localparam logic [4:0] OP_ADD   = 5'd0;
	localparam logic [4:0] OP_ADC   = 5'd1;
	localparam logic [4:0] OP_SUB   = 5'd2;
	localparam logic [4:0] OP_SBC   = 5'd3;
	localparam logic [4:0] OP_AND   = 5'd4;
	localparam logic [4:0] OP_XOR   = 5'd5;
	localparam logic [4:0] OP_OR    = 5'd6;
	localparam logic [4:0] OP_CP    = 5'd7;
	localparam logic [4:0] OP_INC8  = 5'd8;
	localparam logic [4:0] OP_DEC8  = 5'd9;
	localparam logic [4:0] OP_RLC   = 5'd10;
	localparam logic [4:0] OP_RRC   = 5'd11;
	localparam logic [4:0] OP_RL    = 5'd12;
	localparam logic [4:0] OP_RR    = 5'd13;
	localparam logic [4:0] OP_SLA   = 5'd14;
	localparam logic [4:0] OP_SRA   = 5'd15;
	localparam logic [4:0] OP_SWAP  = 5'd16;
	localparam logic [4:0] OP_SRL   = 5'd17;
	localparam logic [4:0] OP_BIT   = 5'd18;
	localparam logic [4:0] OP_RES   = 5'd19;
	localparam logic [4:0] OP_SET   = 5'd20;
	localparam logic [4:0] OP_DAA   = 5'd21;
	localparam logic [4:0] OP_CPL   = 5'd22;
	localparam logic [4:0] OP_CCF   = 5'd23;
	localparam logic [4:0] OP_SCF   = 5'd24;
	localparam logic [4:0] OP_ADDHL = 5'd25;
	localparam logic [4:0] OP_ADDSP = 5'd26;
	localparam logic [4:0] OP_LDHLSP = 5'd27;
	localparam logic [4:0] OP_INC16 = 5'd28;
	localparam logic [4:0] OP_DEC16 = 5'd29;

	// Decimal adjust constants
	localparam logic [7:0] DAA_LO_ADJ = 8'h06;
	localparam logic [7:0] DAA_HI_ADJ = 8'h60;
	localparam logic [3:0] DAA_LO_MAX = 4'h9;
	localparam logic [7:0] DAA_MAX    = 8'h99;

	typedef struct packed {
		logic [4:0]  action;
		logic [15:0] operand_x;
		logic [15:0] operand_y;
		logic [2:0]  bit_index;
		logic [3:0]  flags_in;
	} req_t;

	typedef struct packed {
		logic [15:0] result_value;
		logic [3:0]  flags_out;
	} rsp_t;

endpackage

### rtl/eight_bit_alu_with_flags.sv
// eight_bit_alu_with_flags: 8-bit CPU ALU with Z/N/H/C flags, two-register pipeline.
// Depends on ebalu_pkg (request/response structs, operation codes).
//
// Usage:
//  - Request channel (req_valid/req_ready/req): one operation per request:
//    action code, two 16-bit operands, a bit index and the incoming flags.
//  - Response channel (rsp_valid/rsp_ready/rsp): the result value and new
//    flags, one response per request, in request order.
//  - Path: an accepted request is loaded into the input register, computed,
//    and loaded into the result register, which drives the response.
//  - Throughput: one request per cycle while rsp_ready stays high. The whole
//    operation is one pass of combinational logic between the input register
//    (_s1) and the result register (_s2); no iteration, no state between requests.
//  - Stall: when rsp_ready is low, the response holds in the result
//    register; the input register still takes a request if it is empty,
//    so up to two requests sit in the block before req_ready drops.
//  - Reset (arst_n low, asynchronous) empties both stages; there is no
//    other state. Unused action codes return operand_x and flags_in.
module eight_bit_alu_with_flags (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  ebalu_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output ebalu_pkg::rsp_t   rsp
);

	// ---------------- pipeline control ----------------
	logic            valid_s1;
	logic            valid_s2;
	logic            adv_s2;   // stage 2 loads this cycle
	logic            adv_s1;   // stage 1 loads this cycle
	ebalu_pkg::req_t req_s1;
	ebalu_pkg::rsp_t rsp_s2;
	ebalu_pkg::rsp_t rsp_next;

	// Stage 2 can load when empty or when its response leaves now
	assign adv_s2    = valid_s1 && (!valid_s2 || rsp_ready);
	// Stage 1 can load when empty or when its request moves on now
	assign req_ready = !valid_s1 || adv_s2;
	assign adv_s1    = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready)
				valid_s1 <= req_valid;
			if (!valid_s2 || rsp_ready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			req_s1 <= req;
		if (adv_s2)
			rsp_s2 <= rsp_next;
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	// ---------------- operation logic ----------------
	logic [4:0]  op;
	logic [15:0] x, y;
	logic [7:0]  a, v;
	logic [3:0]  fin;
	logic        cin;
	logic        cy_add, cy_sub;   // carry/borrow in for adc/sbc
	logic [8:0]  add9, sub9;
	logic [4:0]  addh5, subh5;
	logic [7:0]  inc8, dec8;
	logic [7:0]  bmask;
	logic [7:0]  daa_adj;
	logic        daa_lo, daa_hi;
	logic [7:0]  daa_res;
	logic [16:0] hl17;
	logic [12:0] hl13;
	logic [15:0] sp16;
	logic [4:0]  sph5;
	logic [8:0]  spc9;
	logic [7:0]  r8;
	logic        r8_used;
	logic [15:0] r16;
	logic [3:0]  f;

	assign op  = req_s1.action;
	assign x   = req_s1.operand_x;
	assign y   = req_s1.operand_y;
	assign fin = req_s1.flags_in;
	assign a   = x[7:0];
	assign v   = y[7:0];
	assign cin = fin[ebalu_pkg::FLAG_C];

	assign cy_add = (op == ebalu_pkg::OP_ADC) && cin;
	assign cy_sub = (op == ebalu_pkg::OP_SBC) && cin;

	assign add9  = {1'b0, a} + {1'b0, v} + {8'd0, cy_add};
	assign addh5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cy_add};
	// Bit 8 / bit 4 of the difference is the borrow
	assign sub9  = {1'b0, a} - {1'b0, v} - {8'd0, cy_sub};
	assign subh5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cy_sub};

	assign inc8  = a + 8'd1;
	assign dec8  = a - 8'd1;
	assign bmask = 8'd1 << req_s1.bit_index;

	// Decimal adjust
	always_comb begin
		daa_lo  = 1'b0;
		daa_hi  = 1'b0;
		daa_adj = 8'd0;
		daa_res = 8'd0;
		if (fin[ebalu_pkg::FLAG_N]) begin
			daa_lo  = fin[ebalu_pkg::FLAG_H];
			daa_hi  = fin[ebalu_pkg::FLAG_C];
			daa_adj = (daa_lo ? ebalu_pkg::DAA_LO_ADJ : 8'd0)
			        | (daa_hi ? ebalu_pkg::DAA_HI_ADJ : 8'd0);
			daa_res = a - daa_adj;
		end else begin
			daa_lo  = fin[ebalu_pkg::FLAG_H] || (a[3:0] > ebalu_pkg::DAA_LO_MAX);
			daa_hi  = fin[ebalu_pkg::FLAG_C] || (a > ebalu_pkg::DAA_MAX);
			daa_adj = (daa_lo ? ebalu_pkg::DAA_LO_ADJ : 8'd0)
			        | (daa_hi ? ebalu_pkg::DAA_HI_ADJ : 8'd0);
			daa_res = a + daa_adj;
		end
	end

	// 16-bit HL add: H from bit 11, C from bit 15
	assign hl17 = {1'b0, x} + {1'b0, y};
	assign hl13 = {1'b0, x[11:0]} + {1'b0, y[11:0]};

	// SP plus signed byte: flags from unsigned low-nibble and low-byte adds
	assign sp16 = x + {{8{v[7]}}, v};
	assign sph5 = {1'b0, x[3:0]} + {1'b0, v[3:0]};
	assign spc9 = {1'b0, x[7:0]} + {1'b0, v};

	always_comb begin
		r8      = 8'd0;
		r8_used = 1'b1;
		r16     = x;
		f       = fin;
		case (op)
			ebalu_pkg::OP_ADD, ebalu_pkg::OP_ADC: begin
				r8 = add9[7:0];
				f  = {(add9[7:0] == 8'd0), 1'b0, addh5[4], add9[8]};
			end
			ebalu_pkg::OP_SUB, ebalu_pkg::OP_SBC: begin
				r8 = sub9[7:0];
				f  = {(sub9[7:0] == 8'd0), 1'b1, subh5[4], sub9[8]};
			end
			ebalu_pkg::OP_CP: begin
				r8_used = 1'b0;   // compare keeps the full operand
				f  = {(sub9[7:0] == 8'd0), 1'b1, subh5[4], sub9[8]};
			end
			ebalu_pkg::OP_AND: begin
				r8 = a & v;
				f  = {((a & v) == 8'd0), 1'b0, 1'b1, 1'b0};
			end
			ebalu_pkg::OP_XOR: begin
				r8 = a ^ v;
				f  = {((a ^ v) == 8'd0), 3'b000};
			end
			ebalu_pkg::OP_OR: begin
				r8 = a | v;
				f  = {((a | v) == 8'd0), 3'b000};
			end
			ebalu_pkg::OP_INC8: begin
				r8 = inc8;
				f  = {(inc8 == 8'd0), 1'b0, (inc8[3:0] == 4'h0), cin};
			end
			ebalu_pkg::OP_DEC8: begin
				r8 = dec8;
				f  = {(dec8 == 8'd0), 1'b1, (dec8[3:0] == 4'hF), cin};
			end
			ebalu_pkg::OP_RLC: begin
				r8 = {a[6:0], a[7]};
				f  = {(a == 8'd0), 2'b00, a[7]};
			end
			ebalu_pkg::OP_RRC: begin
				r8 = {a[0], a[7:1]};
				f  = {(a == 8'd0), 2'b00, a[0]};
			end
			ebalu_pkg::OP_RL: begin
				r8 = {a[6:0], cin};
				f  = {({a[6:0], cin} == 8'd0), 2'b00, a[7]};
			end
			ebalu_pkg::OP_RR: begin
				r8 = {cin, a[7:1]};
				f  = {({cin, a[7:1]} == 8'd0), 2'b00, a[0]};
			end
			ebalu_pkg::OP_SLA: begin
				r8 = {a[6:0], 1'b0};
				f  = {(a[6:0] == 7'd0), 2'b00, a[7]};
			end
			ebalu_pkg::OP_SRA: begin
				r8 = {a[7], a[7:1]};
				f  = {(a[7:1] == 7'd0), 2'b00, a[0]};
			end
			ebalu_pkg::OP_SWAP: begin
				r8 = {a[3:0], a[7:4]};
				f  = {(a == 8'd0), 3'b000};
			end
			ebalu_pkg::OP_SRL: begin
				r8 = {1'b0, a[7:1]};
				f  = {(a[7:1] == 7'd0), 2'b00, a[0]};
			end
			ebalu_pkg::OP_BIT: begin
				r8_used = 1'b0;   // bit test keeps the full operand
				f  = {((a & bmask) == 8'd0), 1'b0, 1'b1, cin};
			end
			ebalu_pkg::OP_RES: begin
				r8 = a & ~bmask;
			end
			ebalu_pkg::OP_SET: begin
				r8 = a | bmask;
			end
			ebalu_pkg::OP_DAA: begin
				r8 = daa_res;
				f  = {(daa_res == 8'd0), fin[ebalu_pkg::FLAG_N], 1'b0,
				      cin | (~fin[ebalu_pkg::FLAG_N] & daa_hi)};
			end
			ebalu_pkg::OP_CPL: begin
				r8 = ~a;
				f  = {fin[ebalu_pkg::FLAG_Z], 2'b11, cin};
			end
			ebalu_pkg::OP_CCF: begin
				r8_used = 1'b0;
				f  = {fin[ebalu_pkg::FLAG_Z], 2'b00, ~cin};
			end
			ebalu_pkg::OP_SCF: begin
				r8_used = 1'b0;
				f  = {fin[ebalu_pkg::FLAG_Z], 2'b00, 1'b1};
			end
			ebalu_pkg::OP_ADDHL: begin
				r8_used = 1'b0;
				r16 = hl17[15:0];
				f   = {fin[ebalu_pkg::FLAG_Z], 1'b0, hl13[12], hl17[16]};
			end
			ebalu_pkg::OP_ADDSP, ebalu_pkg::OP_LDHLSP: begin
				r8_used = 1'b0;
				r16 = sp16;
				f   = {2'b00, sph5[4], spc9[8]};
			end
			ebalu_pkg::OP_INC16: begin
				r8_used = 1'b0;
				r16 = x + 16'd1;
			end
			ebalu_pkg::OP_DEC16: begin
				r8_used = 1'b0;
				r16 = x - 16'd1;
			end
			default: begin
				r8_used = 1'b0;   // unused codes pass operand and flags through
			end
		endcase
	end

	// 8-bit results come back with a zero high byte
	assign rsp_next.result_value = r8_used ? {8'd0, r8} : r16;
	assign rsp_next.flags_out    = f;

endmodule

### tb/alu_result_checker.sv
// alu_result_checker: watches the request and response channels of the ALU,
// predicts each response from its request, and counts mismatches.
// Depends on ebalu_pkg for req_t, rsp_t, operation codes and flag positions.
`timescale 1ns / 100ps

module alu_result_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_ready,
	input  ebalu_pkg::req_t req,
	input  logic            rsp_valid,
	input  logic            rsp_ready,
	input  ebalu_pkg::rsp_t rsp,
	output int unsigned     mismatch_count,
	output int unsigned     results_owed
);

	typedef struct {
		ebalu_pkg::req_t request;
		ebalu_pkg::rsp_t outcome;
	} pending_t;

	pending_t    pending_results[$];
	int unsigned mismatch_tally = 0;

	assign mismatch_count = mismatch_tally;

	function automatic logic [3:0] pack_flags(logic [7:0] r8, logic n, logic h, logic c);
		return {r8 == 8'h00, n, h, c};
	endfunction

	function automatic ebalu_pkg::rsp_t alu_compute(ebalu_pkg::req_t q);
		ebalu_pkg::rsp_t o;
		logic [7:0]  a, v, r8, adj;
		logic [15:0] x, y;
		logic [3:0]  f;
		logic        cin, ci, hc, cy, byte_result;
		int unsigned wide;
		a = q.operand_x[7:0];
		v = q.operand_y[7:0];
		x = q.operand_x;
		y = q.operand_y;
		f = q.flags_in;
		cin = f[ebalu_pkg::FLAG_C];
		ci = 1'b0;
		r8 = 8'h00;
		adj = 8'h00;
		byte_result = 1'b1;
		o.result_value = x;
		case (q.action)
			ebalu_pkg::OP_ADD, ebalu_pkg::OP_ADC: begin
				ci = (q.action == ebalu_pkg::OP_ADC) ? cin : 1'b0;
				wide = int'(a) + int'(v) + int'(ci);
				hc = int'(a[3:0]) + int'(v[3:0]) + int'(ci) > 15;
				r8 = wide[7:0];
				f = pack_flags(r8, 1'b0, hc, wide[8]);
			end
			ebalu_pkg::OP_SUB, ebalu_pkg::OP_SBC, ebalu_pkg::OP_CP: begin
				ci = (q.action == ebalu_pkg::OP_SBC) ? cin : 1'b0;
				r8 = a - v - {7'd0, ci};
				hc = int'(a[3:0]) < int'(v[3:0]) + int'(ci);
				cy = int'(a) < int'(v) + int'(ci);
				f = pack_flags(r8, 1'b1, hc, cy);
				byte_result = (q.action != ebalu_pkg::OP_CP);
			end
			ebalu_pkg::OP_AND: begin
				r8 = a & v;
				f = pack_flags(r8, 1'b0, 1'b1, 1'b0);
			end
			ebalu_pkg::OP_XOR, ebalu_pkg::OP_OR: begin
				r8 = (q.action == ebalu_pkg::OP_XOR) ? (a ^ v) : (a | v);
				f = pack_flags(r8, 1'b0, 1'b0, 1'b0);
			end
			ebalu_pkg::OP_INC8: begin
				r8 = a + 8'd1;
				f = pack_flags(r8, 1'b0, r8[3:0] == 4'h0, cin);
			end
			ebalu_pkg::OP_DEC8: begin
				r8 = a - 8'd1;
				f = pack_flags(r8, 1'b1, r8[3:0] == 4'hF, cin);
			end
			ebalu_pkg::OP_RLC: begin
				r8 = {a[6:0], a[7]};
				f = pack_flags(r8, 1'b0, 1'b0, a[7]);
			end
			ebalu_pkg::OP_RRC: begin
				r8 = {a[0], a[7:1]};
				f = pack_flags(r8, 1'b0, 1'b0, a[0]);
			end
			ebalu_pkg::OP_RL: begin
				r8 = {a[6:0], cin};
				f = pack_flags(r8, 1'b0, 1'b0, a[7]);
			end
			ebalu_pkg::OP_RR: begin
				r8 = {cin, a[7:1]};
				f = pack_flags(r8, 1'b0, 1'b0, a[0]);
			end
			ebalu_pkg::OP_SLA: begin
				r8 = {a[6:0], 1'b0};
				f = pack_flags(r8, 1'b0, 1'b0, a[7]);
			end
			ebalu_pkg::OP_SRA: begin
				r8 = {a[7], a[7:1]};
				f = pack_flags(r8, 1'b0, 1'b0, a[0]);
			end
			ebalu_pkg::OP_SWAP: begin
				r8 = {a[3:0], a[7:4]};
				f = pack_flags(r8, 1'b0, 1'b0, 1'b0);
			end
			ebalu_pkg::OP_SRL: begin
				r8 = {1'b0, a[7:1]};
				f = pack_flags(r8, 1'b0, 1'b0, a[0]);
			end
			ebalu_pkg::OP_BIT: begin
				f[ebalu_pkg::FLAG_Z] = ~a[q.bit_index];
				f[ebalu_pkg::FLAG_N] = 1'b0;
				f[ebalu_pkg::FLAG_H] = 1'b1;
				byte_result = 1'b0;
			end
			ebalu_pkg::OP_RES, ebalu_pkg::OP_SET: begin
				r8 = a;
				r8[q.bit_index] = (q.action == ebalu_pkg::OP_SET);
			end
			ebalu_pkg::OP_DAA: begin
				if (f[ebalu_pkg::FLAG_N]) begin
					if (f[ebalu_pkg::FLAG_H]) adj = adj + ebalu_pkg::DAA_LO_ADJ;
					if (f[ebalu_pkg::FLAG_C]) adj = adj + ebalu_pkg::DAA_HI_ADJ;
					r8 = a - adj;
				end else begin
					if (f[ebalu_pkg::FLAG_H] || a[3:0] > ebalu_pkg::DAA_LO_MAX)
						adj = adj + ebalu_pkg::DAA_LO_ADJ;
					if (f[ebalu_pkg::FLAG_C] || a > ebalu_pkg::DAA_MAX) begin
						adj = adj + ebalu_pkg::DAA_HI_ADJ;
						f[ebalu_pkg::FLAG_C] = 1'b1;
					end
					r8 = a + adj;
				end
				f[ebalu_pkg::FLAG_Z] = (r8 == 8'h00);
				f[ebalu_pkg::FLAG_H] = 1'b0;
			end
			ebalu_pkg::OP_CPL: begin
				r8 = ~a;
				f[ebalu_pkg::FLAG_N] = 1'b1;
				f[ebalu_pkg::FLAG_H] = 1'b1;
			end
			ebalu_pkg::OP_CCF, ebalu_pkg::OP_SCF: begin
				f[ebalu_pkg::FLAG_N] = 1'b0;
				f[ebalu_pkg::FLAG_H] = 1'b0;
				f[ebalu_pkg::FLAG_C] = (q.action == ebalu_pkg::OP_SCF) ? 1'b1
					: ~f[ebalu_pkg::FLAG_C];
				byte_result = 1'b0;
			end
			ebalu_pkg::OP_ADDHL: begin
				wide = int'(x) + int'(y);
				o.result_value = wide[15:0];
				f[ebalu_pkg::FLAG_N] = 1'b0;
				f[ebalu_pkg::FLAG_H] = int'(x[11:0]) + int'(y[11:0]) > 32'h0FFF;
				f[ebalu_pkg::FLAG_C] = wide[16];
				byte_result = 1'b0;
			end
			ebalu_pkg::OP_ADDSP, ebalu_pkg::OP_LDHLSP: begin
				// displacement is the sign-extended low byte; flags from unsigned byte sums
				o.result_value = x + {{8{v[7]}}, v};
				f = {1'b0, 1'b0, int'(x[3:0]) + int'(v[3:0]) > 15,
					int'(x[7:0]) + int'(v) > 255};
				byte_result = 1'b0;
			end
			ebalu_pkg::OP_INC16: begin
				o.result_value = x + 16'd1;
				byte_result = 1'b0;
			end
			ebalu_pkg::OP_DEC16: begin
				o.result_value = x - 16'd1;
				byte_result = 1'b0;
			end
			default: begin
				byte_result = 1'b0;
			end
		endcase
		if (byte_result) o.result_value = {8'h00, r8};
		o.flags_out = f;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] seen,
			input logic [15:0] wanted, input ebalu_pkg::req_t cause);
		$display("MISMATCH at %0t: %s got %h expected %h (action %0d x %h y %h bit %0d flags %h)",
			$time, what, seen, wanted, cause.action, cause.operand_x, cause.operand_y,
			cause.bit_index, cause.flags_in);
		mismatch_tally++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pending_t head;
		pending_t entry;
		if (!arst_n) begin
			pending_results.delete();
			results_owed <= 0;
		end else begin
			if (req_valid && req_ready) begin
				entry.request = req;
				entry.outcome = alu_compute(req);
				pending_results.insert(pending_results.size(), entry);
			end
			if (rsp_valid && rsp_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected response", rsp.result_value, 16'h0000, '0);
				end else begin
					head = pending_results.pop_front();
					if (rsp.result_value !== head.outcome.result_value)
						report_mismatch("result_value", rsp.result_value,
							head.outcome.result_value, head.request);
					if (rsp.flags_out !== head.outcome.flags_out)
						report_mismatch("flags_out", {12'h000, rsp.flags_out},
							{12'h000, head.outcome.flags_out}, head.request);
				end
			end
			results_owed <= pending_results.size();
		end
	end

endmodule

### tb/testbench.sv
// testbench: drives requests into eight_bit_alu_with_flags and throttles its responses.
// Depends on ebalu_pkg, the ALU RTL and alu_result_checker (prediction and compare).
`timescale 1ns / 100ps

module testbench;

	// Longest run of cycles with no handshake on either channel before giving up.
	// Worst legit stretch is the LONG_HOLD_CYCLES receiver hold plus one random idle burst.
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned LONG_HOLD_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	ebalu_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	ebalu_pkg::rsp_t rsp;

	int unsigned mismatch_count;
	int unsigned results_owed;
	int unsigned quiet_cycles = 0;

	// Shared knobs between the request and response processes
	bit idling_on = 1'b1;
	bit hold_burst = 1'b0;

	always #5 clk = ~clk;

	eight_bit_alu_with_flags dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	alu_result_checker result_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.rsp            (rsp),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	// Operand mix: corners, BCD-looking bytes for decimal adjust, and plain noise.
	function automatic logic [15:0] random_word();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return {8'h00, 8'($urandom)};
			3: begin
				case ($urandom_range(0, 5))
					0: return 16'h00FF;
					1: return 16'h0FFF;
					2: return 16'h8000;
					3: return 16'h7FFF;
					4: return 16'h0F0F;
					default: return 16'h0080;
				endcase
			end
			4: return {8'($urandom), 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
			default: return 16'($urandom);
		endcase
	endfunction

	// Unused codes 30 and 31 show up now and then; they must pass operands through.
	function automatic ebalu_pkg::req_t random_request();
		ebalu_pkg::req_t q;
		if ($urandom_range(0, 19) == 0)
			q.action = 5'($urandom_range(30, 31));
		else
			q.action = 5'($urandom_range(0, 29));
		q.operand_x = random_word();
		q.operand_y = random_word();
		q.bit_index = 3'($urandom);
		q.flags_in = 4'($urandom);
		return q;
	endfunction

	// Present one request and hold it until the edge that accepts it.
	// Returns at that edge, so the caller may drive the next request at once.
	task automatic offer_request(input ebalu_pkg::req_t item);
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
	endtask

	// Random sender gap after an accepted request; only while idling is on.
	task automatic maybe_pause();
		if (idling_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Sender goes quiet until every request has been answered.
	task automatic wait_for_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
	endtask

	task automatic send_random_requests(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			offer_request(random_request());
			maybe_pause();
		end
	endtask

	// Request side: reset, directed sweep, random phases, drain, verdict.
	initial begin
		ebalu_pkg::req_t item;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sweep: one request per action code, unused codes included,
		// with operands rotating through all-ones, zero, byte max and sign corners
		// so wraps, zero results and full carries come up early.
		for (int k = 0; k < 32; k++) begin
			item.action = 5'(k);
			case (k % 4)
				0: item.operand_x = 16'hFFFF;
				1: item.operand_x = 16'h0000;
				2: item.operand_x = 16'h00FF;
				default: item.operand_x = 16'h8001;
			endcase
			case (k % 3)
				0: item.operand_y = 16'h0001;
				1: item.operand_y = 16'hFFFF;
				default: item.operand_y = 16'h0080;
			endcase
			item.bit_index = 3'(k);
			item.flags_in = 4'(k);
			offer_request(item);
			maybe_pause();
		end
		wait_for_results();

		// Random traffic with idling on both sides
		send_random_requests(330);

		// Backpressure: receiver holds off for a long stretch while requests keep
		// coming back to back, so the two stages fill and req_ready drops.
		hold_burst = 1'b1;
		for (int k = 0; k < 24; k++)
			offer_request(random_request());

		// Full drain in the middle of the run
		wait_for_results();
		send_random_requests(240);

		// Last stretch: no idling anywhere, one request per cycle
		idling_on = 1'b0;
		send_random_requests(150);

		wait_for_results();
		repeat (6) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Response side: random ready bursts, one long hold when asked, steady at the end.
	initial begin
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_burst) begin
				hold_burst = 1'b0;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat (idling_on ? $urandom_range(1, 10) : 1) @(posedge clk);
			end
		end
	end

	// Watchdog: no handshake on either channel for too long means a hang.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

### eight_bit_alu_with_flags.f
rtl/ebalu_pkg.sv
rtl/eight_bit_alu_with_flags.sv
tb/alu_result_checker.sv
tb/testbench.sv
